[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/chsp_pkg.sv]
// Types, codes and constant arithmetic for the clock hand stepper positioner.
package chsp_pkg;

    localparam int unsigned CHSP_CAL_STEPS = 600;

    localparam int unsigned CMD_W   = 2;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned RAW_W   = 14;
    localparam int unsigned DEG_W   = 9;
    localparam int unsigned STEPS_W = 10;
    localparam int unsigned MODE_W  = 2;

    // raw * 0.021972 == raw * 5493 / 250000
    localparam int unsigned PROD_W    = 27;
    localparam int unsigned RECIP_W   = 28;
    localparam int unsigned ANG_SHIFT = 45;
    localparam logic [12:0] ANG_NUM   = 13'd5493;
    // ceil(2^45 / 250000): exact quotient for any 27-bit product
    localparam logic [RECIP_W-1:0] ANG_RECIP = 28'd140737489;

    localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_TOP  = 2'd1,
        CMD_CAL  = 2'd2
    } chsp_cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEC  = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_HOUR = 2'd2
    } chsp_mode_t;

    typedef enum logic {
        CFG_CLOCK_MODE = 1'b0,
        CFG_HOLD_HANDS = 1'b1
    } chsp_cfg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEC_W-1:0]  sec_now;
        logic [MIN_W-1:0]  min_now;
        logic [HOUR_W-1:0] hour_now;
        logic [RAW_W-1:0]  angle_raw;
    } chsp_in_t;

    typedef struct packed {
        logic               step_pulse;
        logic               step_dir;
        logic [DEG_W-1:0]   goal_angle;
        logic [STEPS_W-1:0] steps_pending;
        logic               calibrating;
    } chsp_out_t;

    // floor(d * 5 / 9) for d < 360, as d * 18205 >> 15
    function automatic logic [7:0] deg_to_steps(input logic [DEG_W-1:0] d);
        logic [22:0] prod;
        prod = 23'(d) * 23'd18205;
        return prod[22:15];
    endfunction

endpackage

[hw/rtl/clock_hand_stepper_positioner_top.sv]
// Clock hand stepper positioner: three-stage pipeline, one beat per cycle.
//
// Takes one command beat per clock and returns exactly one result beat for it,
// from the result register once both earlier stages pass it on. A sustained rate
// of one beat per cycle holds as long as out_stall stays low; each of the three
// registers (input/angle product, angle and time position, result) advances
// independently, so a stalled result only backs up into the earlier stages. The
// first stage registers raw*5493; the second turns it into whole degrees with a
// 27x28 reciprocal multiply and forms 360 - 6*position from the selected clock
// field; the third holds the stepper state (pending steps, direction, top-sensor
// offset, calibration flag, last second, goal) and produces the result beat.
// clock_mode and hold_hands are written through the cfg port, which is always
// ready; write them only while no beat is in flight.
`include "assert_macros.svh"

module clock_hand_stepper_positioner_top
    import chsp_pkg::*;
#(
    parameter int unsigned CAL_STEPS = CHSP_CAL_STEPS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  chsp_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output chsp_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [MODE_W-1:0] cfg_data
);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SEC_W-1:0]  sec_now;
        logic [MIN_W-1:0]  min_now;
        logic [HOUR_W-1:0] hour_now;
        logic [PROD_W-1:0] prod;
    } stage_a_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEC_W-1:0] sec_now;
        logic [DEG_W-1:0] angle;
        logic [DEG_W-1:0] goal_base;
    } stage_b_t;

    // config registers
    logic [MODE_W-1:0] clock_mode_reg;
    logic              hold_hands_reg;

    // pipeline registers
    logic      a_valid_reg, b_valid_reg, out_valid_reg;
    stage_a_t  a_reg;
    stage_b_t  b_reg;
    chsp_out_t out_reg;

    // stepper state
    logic [STEPS_W-1:0] steps_left_reg, steps_left_next;
    logic               move_dir_reg, move_dir_next;
    logic               cal_active_reg, cal_active_next;
    logic [DEG_W-1:0]   top_offset_reg, top_offset_next;
    logic [SEC_W-1:0]   last_sec_reg, last_sec_next;
    logic [DEG_W-1:0]   goal_reg, goal_next;
    logic               pulse, pulse_dir;

    logic out_adv, b_adv, a_adv, c_fire;

    // ---------------- flow control ----------------
    // Each stage can load when it is empty or its content moves on this edge.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign b_adv    = !b_valid_reg || out_adv;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;
    assign c_fire   = b_valid_reg && out_adv;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_mode_reg <= '0;
            hold_hands_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (chsp_cfg_idx_t'(cfg_index))
                CFG_CLOCK_MODE: clock_mode_reg <= cfg_data;
                CFG_HOLD_HANDS: hold_hands_reg <= cfg_data[0];
            endcase
        end
    end

    // ---------------- stage A: sensor product ----------------
    stage_a_t a_next;
    always_comb
    begin
        a_next.command  = in_data.command;
        a_next.sec_now  = in_data.sec_now;
        a_next.min_now  = in_data.min_now;
        a_next.hour_now = in_data.hour_now;
        a_next.prod     = PROD_W'(in_data.angle_raw) * PROD_W'(ANG_NUM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_adv)
            a_reg <= a_next;
    end

    // ---------------- stage B: degrees and clock position ----------------
    logic [PROD_W+RECIP_W-1:0] ang_full;
    logic [HOUR_W-2:0]         hour12;
    logic [11:0]               min_mul;
    logic [6:0]                hour_pos, pos_sel;
    logic [SEC_W-1:0]          pos_m;
    stage_b_t                  b_next;

    always_comb
    begin
        ang_full = (PROD_W+RECIP_W)'(a_reg.prod) * (PROD_W+RECIP_W)'(ANG_RECIP);

        // hour mod 12 (hour field tops out at 31)
        if (a_reg.hour_now >= HOUR_W'(24))
            hour12 = (HOUR_W-1)'(a_reg.hour_now - HOUR_W'(24));
        else if (a_reg.hour_now >= HOUR_W'(12))
            hour12 = (HOUR_W-1)'(a_reg.hour_now - HOUR_W'(12));
        else
            hour12 = (HOUR_W-1)'(a_reg.hour_now);

        // min/12 == min*43 >> 9 for min < 64
        min_mul  = 12'(a_reg.min_now) * 12'd43;
        hour_pos = 7'(hour12) * 7'd5 + 7'(min_mul[11:9]);

        unique case (chsp_mode_t'(clock_mode_reg))
            MODE_MIN:  pos_sel = 7'(a_reg.min_now);
            MODE_HOUR: pos_sel = hour_pos;
            default:   pos_sel = 7'(a_reg.sec_now);
        endcase

        pos_m = (pos_sel >= 7'd60) ? SEC_W'(pos_sel - 7'd60) : SEC_W'(pos_sel);

        b_next.command   = a_reg.command;
        b_next.sec_now   = a_reg.sec_now;
        b_next.angle     = ang_full[ANG_SHIFT+DEG_W-1:ANG_SHIFT];
        b_next.goal_base = DEG_FULL - DEG_W'(DEG_W'(pos_m) * DEG_W'(6));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_adv)
            b_reg <= b_next;
    end

    // ---------------- stage C: stepper state and result ----------------
    logic [DEG_W:0]   goal_sum;
    logic [DEG_W-1:0] goal_new, fwd_d, rev_d;
    logic [DEG_W:0]   fwd_raw;
    logic [7:0]       fwd_s, rev_s;
    logic             retarget;

    always_comb
    begin
        // goal = 360 - 6*pos + offset, wrapped into 1..360
        goal_sum = (DEG_W+1)'(b_reg.goal_base) + (DEG_W+1)'(top_offset_reg);
        goal_new = (goal_sum > (DEG_W+1)'(DEG_FULL))
                 ? DEG_W'(goal_sum - (DEG_W+1)'(DEG_FULL)) : DEG_W'(goal_sum);

        // forward distance angle -> goal; reverse is its complement
        fwd_raw = (DEG_W+1)'(b_reg.angle) - (DEG_W+1)'(goal_new);
        if (b_reg.angle < goal_new)
            fwd_raw = fwd_raw + (DEG_W+1)'(DEG_FULL);
        fwd_d = DEG_W'(fwd_raw);
        rev_d = (fwd_d == '0) ? '0 : DEG_FULL - fwd_d;
        fwd_s = deg_to_steps(fwd_d);
        rev_s = deg_to_steps(rev_d);

        steps_left_next = steps_left_reg;
        move_dir_next   = move_dir_reg;
        cal_active_next = cal_active_reg;
        top_offset_next = top_offset_reg;
        last_sec_next   = last_sec_reg;
        goal_next       = goal_reg;
        pulse           = 1'b0;
        pulse_dir       = 1'b0;
        retarget        = 1'b0;

        unique case (b_reg.command)
            CMD_TICK:
            begin
                if (steps_left_reg != '0)
                begin
                    pulse           = 1'b1;
                    pulse_dir       = move_dir_reg;
                    steps_left_next = steps_left_reg - STEPS_W'(1);
                end
                if (b_reg.sec_now != last_sec_reg)
                begin
                    last_sec_next = b_reg.sec_now;
                    retarget      = !hold_hands_reg && !cal_active_reg;
                end
                if (retarget)
                begin
                    goal_next = goal_new;
                    // ties go forward
                    if (fwd_s <= rev_s)
                    begin
                        move_dir_next   = 1'b0;
                        steps_left_next = STEPS_W'(fwd_s);
                    end
                    else
                    begin
                        move_dir_next   = 1'b1;
                        steps_left_next = STEPS_W'(rev_s);
                    end
                end
            end
            CMD_TOP:
            begin
                top_offset_next = b_reg.angle;
                if (cal_active_reg)
                begin
                    cal_active_next = 1'b0;
                    steps_left_next = '0;
                end
            end
            CMD_CAL:
            begin
                steps_left_next = STEPS_W'(CAL_STEPS);
                move_dir_next   = 1'b0;
                cal_active_next = 1'b1;
            end
            default:
            begin
                // unused command: report status only
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
            move_dir_reg   <= 1'b0;
            cal_active_reg <= 1'b0;
            top_offset_reg <= '0;
            last_sec_reg   <= '0;
            goal_reg       <= '0;
        end
        else if (c_fire)
        begin
            steps_left_reg <= steps_left_next;
            move_dir_reg   <= move_dir_next;
            cal_active_reg <= cal_active_next;
            top_offset_reg <= top_offset_next;
            last_sec_reg   <= last_sec_next;
            goal_reg       <= goal_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_fire)
        begin
            out_reg.step_pulse    <= pulse;
            out_reg.step_dir      <= pulse_dir;
            out_reg.goal_angle    <= goal_next;
            out_reg.steps_pending <= steps_left_next;
            out_reg.calibrating   <= cal_active_next;
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_dir_idle, clk, rst_n, out_valid_reg && !out_reg.step_pulse,
        !out_reg.step_dir)
    `ASSERT_IMP(a_goal_range, clk, rst_n, 1'b1, goal_reg <= DEG_FULL)
    `ASSERT_IMP(a_cal_bound, clk, rst_n, cal_active_reg,
        steps_left_reg <= STEPS_W'(CAL_STEPS))
    `ASSERT_IMP(a_no_stall_empty, clk, rst_n, !a_valid_reg, !in_stall)
    `ASSERT_NXT(a_step_count, clk, rst_n,
        c_fire && b_reg.command == CMD_TICK && steps_left_reg != '0 && !retarget,
        steps_left_reg == $past(steps_left_reg) - STEPS_W'(1))

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the clock hand stepper positioner.
`timescale 1ns / 100ps

module tb_top;
    import chsp_pkg::*;

    localparam int unsigned CLK_HALF     = 5;
    localparam int unsigned RESET_CYCLES = 7;
    // pipeline is three deep; give it a little more before config writes and at the end
    localparam int unsigned DRAIN_CYCLES = 8;
    // ~1450 beats, each with its worst-case idle gap, stall and pipe delay, many times over
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_REPORTS  = 10;

    // encodings the package enums leave unnamed
    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_ALT   = 2'd3;   // decodes as seconds
    localparam logic              HOLD_OFF   = 1'b0;
    localparam logic              HOLD_ON    = 1'b1;
    localparam int unsigned       RAW_MAX    = 16383;

    typedef enum logic {
        ROW_BEAT,
        ROW_REG
    } row_kind_t;

    // one line of the directed table: either a command beat or a register write
    typedef struct {
        row_kind_t         kind;
        chsp_in_t          beat;
        bit                typed;      // status below is typed in, not predicted
        chsp_out_t         status;
        chsp_cfg_idx_t     idx;
        logic [MODE_W-1:0] value;
    } dir_row_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic              hold;
        int unsigned       beats;
    } phase_t;

    // ---------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    chsp_in_t          in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    chsp_out_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [MODE_W-1:0] cfg_data = '0;

    // travels alongside in_data: a typed-in status for directed rows
    bit                in_has_status = 1'b0;
    chsp_out_t         in_typed_status = '0;

    always #(CLK_HALF) clk = ~clk;

    clock_hand_stepper_positioner_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------
    // Hand model: our own copy of the stepper state and the two registers.
    // Everything resets to zero, and reset happens exactly once.
    // ---------------------------------------------------------------------
    logic [MODE_W-1:0]  mdl_mode = '0;
    logic               mdl_hold = 1'b0;
    logic [STEPS_W-1:0] mdl_steps = '0;
    logic               mdl_dir = 1'b0;
    logic               mdl_cal = 1'b0;
    logic [DEG_W-1:0]   mdl_offset = '0;
    logic [SEC_W-1:0]   mdl_last_sec = '0;
    logic [DEG_W-1:0]   mdl_goal = '0;

    chsp_out_t   hand_status_q[$];     // statuses owed by the block, oldest first
    int unsigned beats_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // randomized calendar that the random beats follow
    int unsigned wall_sec = 0;
    int unsigned wall_min = 0;
    int unsigned wall_hour = 0;

    bit send_burst = 1'b0;             // sender runs back to back while set
    bit take_burst = 1'b0;             // receiver never stalls while set
    int unsigned stall_left = 0;

    // Steps needed to go from one whole-degree angle to another the way that wraps at 360;
    // 1.8 degrees per step, rounded down.
    function automatic int unsigned arc_steps(int unsigned from_deg, int unsigned to_deg);
        int unsigned d;
        d = (from_deg >= to_deg) ? (from_deg - to_deg) : (360 + from_deg - to_deg);
        return (d * 5) / 9;
    endfunction

    // Advance the hand model by one beat and return the status the block must report.
    function automatic chsp_out_t next_hand_status(chsp_in_t b);
        int unsigned hand_deg, pos, goal, fwd, rev, s, m, h;
        chsp_out_t   st;
        st = '0;
        // sensor counts to whole degrees: floor(raw * 0.021972)
        hand_deg = int'((longint'(b.angle_raw) * 21972) / 1000000);
        s = b.sec_now;
        m = b.min_now;
        h = b.hour_now;
        case (b.command)
            CMD_TICK:
            begin
                if (mdl_steps != 0)
                begin
                    st.step_pulse = 1'b1;
                    st.step_dir   = mdl_dir;
                    mdl_steps     = mdl_steps - 1'b1;
                end
                // last second tracks the calendar even when hands are held or calibrating
                if (b.sec_now != mdl_last_sec)
                begin
                    mdl_last_sec = b.sec_now;
                    if (!mdl_hold && !mdl_cal)
                    begin
                        if (mdl_mode == MODE_MIN)
                            pos = m;
                        else if (mdl_mode == MODE_HOUR)
                            pos = (h % 12) * 5 + (m * 5) / 60;
                        else
                            pos = s;
                        // out-of-range time folds back modulo 60, so goal lands in 1..360
                        goal = 360 - (pos % 60) * 6 + mdl_offset;
                        if (goal > 360)
                            goal -= 360;
                        fwd = arc_steps(hand_deg, goal);
                        rev = arc_steps(goal, hand_deg);
                        // equal distances go forward
                        if (fwd <= rev)
                        begin
                            mdl_dir   = 1'b0;
                            mdl_steps = STEPS_W'(fwd);
                        end
                        else
                        begin
                            mdl_dir   = 1'b1;
                            mdl_steps = STEPS_W'(rev);
                        end
                        mdl_goal = DEG_W'(goal);
                    end
                end
            end
            CMD_TOP:
            begin
                mdl_offset = DEG_W'(hand_deg);
                if (mdl_cal)
                begin
                    mdl_cal   = 1'b0;
                    mdl_steps = '0;
                end
            end
            CMD_CAL:
            begin
                mdl_steps = STEPS_W'(CHSP_CAL_STEPS);
                mdl_dir   = 1'b0;
                mdl_cal   = 1'b1;
            end
            default:
            begin
                // unused command: state untouched, status only
            end
        endcase
        st.goal_angle    = mdl_goal;
        st.steps_pending = mdl_steps;
        st.calibrating   = mdl_cal;
        return st;
    endfunction

    // ---------------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------------
    function automatic chsp_out_t status_of(bit p, bit d, int unsigned g, int unsigned n, bit c);
        chsp_out_t st;
        st.step_pulse    = p;
        st.step_dir      = d;
        st.goal_angle    = DEG_W'(g);
        st.steps_pending = STEPS_W'(n);
        st.calibrating   = c;
        return st;
    endfunction

    function automatic dir_row_t beat_row(logic [CMD_W-1:0] cmd, int unsigned s, int unsigned m,
                                          int unsigned h, int unsigned raw);
        dir_row_t r;
        r.kind               = ROW_BEAT;
        r.beat.command       = cmd;
        r.beat.sec_now       = SEC_W'(s);
        r.beat.min_now       = MIN_W'(m);
        r.beat.hour_now      = HOUR_W'(h);
        r.beat.angle_raw     = RAW_W'(raw);
        r.typed              = 1'b0;
        r.status             = '0;
        r.idx                = CFG_CLOCK_MODE;
        r.value              = '0;
        return r;
    endfunction

    function automatic dir_row_t known_row(logic [CMD_W-1:0] cmd, int unsigned s, int unsigned m,
                                           int unsigned h, int unsigned raw, chsp_out_t st);
        dir_row_t r;
        r        = beat_row(cmd, s, m, h, raw);
        r.typed  = 1'b1;
        r.status = st;
        return r;
    endfunction

    function automatic dir_row_t reg_row(chsp_cfg_idx_t idx, logic [MODE_W-1:0] v);
        dir_row_t r;
        r       = beat_row(CMD_TICK, 0, 0, 0, 0);
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.value = v;
        return r;
    endfunction

    // Random beat that mostly follows a running calendar so that retargets, step trains
    // and calibrations play out; a few beats carry wild or out-of-range time.
    function automatic chsp_in_t make_clock_beat();
        chsp_in_t    b;
        int unsigned cmd_pick, time_pick;
        cmd_pick  = $urandom_range(0, 99);
        time_pick = $urandom_range(0, 99);
        if (time_pick < 45)
        begin
            wall_sec = (wall_sec + 1) % 60;
            if (wall_sec == 0)
            begin
                wall_min = (wall_min + 1) % 60;
                if (wall_min == 0)
                    wall_hour = (wall_hour + 1) % 24;
            end
        end
        else if (time_pick >= 85 && time_pick < 95)
        begin
            wall_sec  = $urandom_range(0, 59);
            wall_min  = $urandom_range(0, 59);
            wall_hour = $urandom_range(0, 23);
        end
        b.sec_now   = SEC_W'(wall_sec);
        b.min_now   = MIN_W'(wall_min);
        b.hour_now  = HOUR_W'(wall_hour);
        b.angle_raw = RAW_W'($urandom_range(0, RAW_MAX));
        if (time_pick >= 95)
        begin
            // full field widths, beyond what a calendar would give
            b.sec_now  = SEC_W'($urandom_range(0, 63));
            b.min_now  = MIN_W'($urandom_range(0, 63));
            b.hour_now = HOUR_W'($urandom_range(0, 31));
        end
        if (cmd_pick < 82)
            b.command = CMD_TICK;
        else if (cmd_pick < 90)
            b.command = CMD_TOP;
        else if (cmd_pick < 96)
            b.command = CMD_CAL;
        else
            b.command = CMD_UNUSED;
        return b;
    endfunction

    // ---------------------------------------------------------------------
    // Sender: random gap before each beat, then hold it until taken.
    // Called and returns at a rising edge; leaves in_valid high after the beat is taken
    // so a zero gap keeps the channel busy without a low blip.
    // ---------------------------------------------------------------------
    task automatic send_beat(chsp_in_t b, bit typed, chsp_out_t st);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_data         <= b;
        in_has_status   <= typed;
        in_typed_status <= st;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // Register write, only once every beat in flight has come back out.
    task automatic write_reg(chsp_cfg_idx_t idx, logic [MODE_W-1:0] v);
        in_valid <= 1'b0;
        while (beats_seen != beats_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_field(string field, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on result beat %0d: %s expected %0d got %0d",
                     beats_seen, field, want, got);
    endtask

    // ---------------------------------------------------------------------
    // Receiver: after each taken beat draw a random stall length; bursts of no stall.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if ($urandom_range(0, 39) == 0)
                take_burst = !take_burst;
            stall_left = take_burst ? 0 : $urandom_range(0, 19);
        end
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------------------------------------------------------------
    // Monitor: tracks register writes, predicts on every taken input beat and
    // checks every taken result beat against the oldest owed status.
    // Sampling happens at the edge, before any of that edge's updates land.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        chsp_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CLOCK_MODE)
                    mdl_mode = cfg_data;
                else
                    mdl_hold = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                want = next_hand_status(in_data);
                hand_status_q.push_back(in_has_status ? in_typed_status : want);
            end
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (hand_status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing owed", beats_seen);
                end
                else
                begin
                    want = hand_status_q.pop_front();
                    if (out_data.step_pulse !== want.step_pulse)
                        flag_field("step_pulse", want.step_pulse, out_data.step_pulse);
                    if (out_data.step_dir !== want.step_dir)
                        flag_field("step_dir", want.step_dir, out_data.step_dir);
                    if (out_data.goal_angle !== want.goal_angle)
                        flag_field("goal_angle", want.goal_angle, out_data.goal_angle);
                    if (out_data.steps_pending !== want.steps_pending)
                        flag_field("steps_pending", want.steps_pending, out_data.steps_pending);
                    if (out_data.calibrating !== want.calibrating)
                        flag_field("calibrating", want.calibrating, out_data.calibrating);
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: directed table first, then random phases over register settings.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t plan[$];
        phase_t   phases[6];

        // Right after reset: nothing pending, goal 0, registers at seconds / not held.
        plan.push_back(known_row(CMD_TICK, 0, 0, 0, 0, status_of(0, 0, 0, 0, 0)));
        // unused command with every field at its top value: no change at all
        plan.push_back(known_row(CMD_UNUSED, 63, 63, 31, RAW_MAX, status_of(0, 0, 0, 0, 0)));
        // calibration loads the full step count forward
        plan.push_back(known_row(CMD_CAL, 0, 0, 0, 0, status_of(0, 0, 0, 600, 1)));
        // new second during calibration: one step, no retarget
        plan.push_back(known_row(CMD_TICK, 5, 0, 0, 0, status_of(1, 0, 0, 599, 1)));
        // top sensor ends calibration and drops what is left
        plan.push_back(known_row(CMD_TOP, 5, 0, 0, 0, status_of(0, 0, 0, 0, 0)));
        // same second again: nothing happens
        plan.push_back(known_row(CMD_TICK, 5, 0, 0, 0, status_of(0, 0, 0, 0, 0)));
        // half way round from zero: both ways equal, forward wins
        plan.push_back(beat_row(CMD_TICK, 30, 0, 0, 0));
        plan.push_back(beat_row(CMD_TICK, 30, 0, 0, 0));
        // offset at its largest, then a second past 59 and a goal that wraps
        plan.push_back(beat_row(CMD_TOP, 30, 0, 0, RAW_MAX));
        plan.push_back(beat_row(CMD_TICK, 63, 0, 0, RAW_MAX));
        plan.push_back(beat_row(CMD_TICK, 0, 0, 0, RAW_MAX));
        plan.push_back(beat_row(CMD_TOP, 0, 0, 0, 0));
        // minutes, including one past 59
        plan.push_back(reg_row(CFG_CLOCK_MODE, MODE_MIN));
        plan.push_back(beat_row(CMD_TICK, 1, 63, 0, 8191));
        plan.push_back(beat_row(CMD_TICK, 2, 59, 0, 8192));
        // hours folded to 12, noon lands on a goal of 360, out-of-range hour and minute
        plan.push_back(reg_row(CFG_CLOCK_MODE, MODE_HOUR));
        plan.push_back(beat_row(CMD_TICK, 3, 59, 23, 4000));
        plan.push_back(beat_row(CMD_TICK, 4, 0, 12, 0));
        plan.push_back(beat_row(CMD_TICK, 5, 63, 31, 12000));
        plan.push_back(reg_row(CFG_CLOCK_MODE, MODE_ALT));
        plan.push_back(beat_row(CMD_TICK, 59, 0, 0, RAW_MAX));
        // held hands: seconds move on, goal stays
        plan.push_back(reg_row(CFG_HOLD_HANDS, HOLD_ON));
        plan.push_back(beat_row(CMD_TICK, 10, 0, 0, 0));
        plan.push_back(beat_row(CMD_TICK, 11, 0, 0, 100));
        plan.push_back(reg_row(CFG_HOLD_HANDS, HOLD_OFF));
        plan.push_back(reg_row(CFG_CLOCK_MODE, MODE_SEC));
        plan.push_back(beat_row(CMD_TICK, 12, 0, 0, 0));
        plan.push_back(beat_row(CMD_CAL, 12, 0, 0, 0));
        plan.push_back(beat_row(CMD_TOP, 12, 0, 0, 5000));

        phases[0] = '{MODE_SEC,  HOLD_OFF, 300};
        phases[1] = '{MODE_MIN,  HOLD_OFF, 250};
        phases[2] = '{MODE_HOUR, HOLD_OFF, 300};
        phases[3] = '{MODE_ALT,  HOLD_OFF, 200};
        phases[4] = '{MODE_HOUR, HOLD_ON,  150};
        phases[5] = '{MODE_SEC,  HOLD_OFF, 200};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_BEAT)
                send_beat(plan[i].beat, plan[i].typed, plan[i].status);
            else
                write_reg(plan[i].idx, plan[i].value);
        end

        // each phase rewrites both registers while the pipe is empty
        foreach (phases[p])
        begin
            write_reg(CFG_CLOCK_MODE, phases[p].mode);
            write_reg(CFG_HOLD_HANDS, {1'b0, phases[p].hold});
            repeat (phases[p].beats)
                send_beat(make_clock_beat(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (beats_seen != beats_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && hand_status_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
